FILE: design/airf_pkg.sv
// Shared types, constants and codes for the inverse ARMA rainfall filter.
`timescale 1ns / 1ps
`default_nettype none

package airf_pkg;

  // Default model order and the fixed count of coefficient registers per side
  localparam int MAX_ORDER_DEF = 3;
  localparam int NUM_COEF      = 3;

  // APB address width: eight 32-bit registers at byte offsets 0..28
  localparam int CFG_AW = 5;

  // Register map indexes (address bits [4:2])
  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_A1   = 3'd1,
    REG_A2   = 3'd2,
    REG_A3   = 3'd3,
    REG_B0   = 3'd4,
    REG_B1   = 3'd5,
    REG_B2   = 3'd6,
    REG_B3   = 3'd7
  } cfg_reg_e;

  // Input transaction
  typedef struct packed {
    logic signed [31:0] flow_obs;
    logic signed [31:0] rain;
    logic signed [31:0] preset_estimate;
    logic               series_start;
  } airf_in_t;

  // Output transaction
  typedef struct packed {
    logic signed [31:0] estimate;
    logic signed [31:0] flow_kept;
    logic               warming;
    logic               div_fault;
  } airf_out_t;

  // Divider result: ovf means the quotient is at least 2^31
  typedef struct packed {
    logic        ovf;
    logic [30:0] quo;
  } div_res_t;

  // Main sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_ABS,
    ST_DSTART,
    ST_DIV,
    ST_MODEL,
    ST_KEPT,
    ST_OUT
  } airf_state_t;

  // Divider sequencer
  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

endpackage

`default_nettype wire

FILE: design/arma_inverse_rainfall_filter.sv
// Top level of the inverse ARMA rainfall filter: config registers, shared MAC, sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Estimates effective rainfall by inverting an ARMA(n,m) flow model, one transaction at a
// time. A warm-up item goes straight to the output state; a computed item runs the filter
// taps and then the divider, and an item that keeps modelled flow adds the model pass; an
// overflowing quotient ends the division early and a zero b0 skips it. The work is done by
// the one shared 32x32 multiplier, which takes one tap per cycle over 2*MAX_ORDER taps (plus
// the b0 tap for modelled flow), and by the divider, which yields one quotient bit per cycle
// over 31 steps. in_ready is high only while the sequencer is idle; a finished result
// waits in the output register while the next item is accepted.

module arma_inverse_rainfall_filter #(
  parameter int MAX_ORDER = airf_pkg::MAX_ORDER_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire airf_pkg::airf_in_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output airf_pkg::airf_out_t              out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [airf_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int TAP_LAST = 2 * MAX_ORDER;
  localparam int TAP_W    = $clog2(TAP_LAST + 2);
  localparam logic [TAP_W-1:0] TAP_DONE = TAP_W'(TAP_LAST + 1);
  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

  // Configuration registers
  logic [4:0]         mode;
  logic signed [31:0] coef_a [airf_pkg::NUM_COEF];
  logic signed [31:0] coef_b0;
  logic signed [31:0] coef_b [airf_pkg::NUM_COEF];

  // Filter state
  logic signed [31:0] flow_hist [MAX_ORDER];
  logic signed [31:0] est_hist  [MAX_ORDER];
  logic [1:0]         wcount;

  // Per-item registers
  logic signed [31:0] rain_r;
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic               pvld;
  logic [TAP_W-1:0]   tap;
  logic [63:0]        mag;
  logic [31:0]        dvsr;
  logic               neg;
  logic signed [31:0] est_r;
  logic signed [31:0] kept_r;
  logic               warm_r;
  logic               fault_r;

  airf_pkg::airf_state_t state;
  airf_pkg::airf_state_t state_next;

  logic               div_start;
  logic               div_done;
  airf_pkg::div_res_t div_res;

  // ---------------------------------------------------------------- APB
  airf_pkg::cfg_reg_e cfg_idx;
  logic               cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = airf_pkg::cfg_reg_e'(paddr[airf_pkg::CFG_AW-1:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= '0;
      coef_b0 <= 32'sh0100_0000;
      for (int i = 0; i < airf_pkg::NUM_COEF; i++) begin
        coef_a[i] <= '0;
        coef_b[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        airf_pkg::REG_MODE: mode      <= pwdata[4:0];
        airf_pkg::REG_A1:   coef_a[0] <= pwdata;
        airf_pkg::REG_A2:   coef_a[1] <= pwdata;
        airf_pkg::REG_A3:   coef_a[2] <= pwdata;
        airf_pkg::REG_B0:   coef_b0   <= pwdata;
        airf_pkg::REG_B1:   coef_b[0] <= pwdata;
        airf_pkg::REG_B2:   coef_b[1] <= pwdata;
        airf_pkg::REG_B3:   coef_b[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      airf_pkg::REG_MODE: prdata = {27'd0, mode};
      airf_pkg::REG_A1:   prdata = coef_a[0];
      airf_pkg::REG_A2:   prdata = coef_a[1];
      airf_pkg::REG_A3:   prdata = coef_a[2];
      airf_pkg::REG_B0:   prdata = coef_b0;
      airf_pkg::REG_B1:   prdata = coef_b[0];
      airf_pkg::REG_B2:   prdata = coef_b[1];
      airf_pkg::REG_B3:   prdata = coef_b[2];
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- mode decode
  logic [1:0] n_ord;
  logic [1:0] m_ord;
  logic [1:0] lead;
  logic       use_model;
  logic [1:0] wc_in;
  logic       warm_in;

  assign n_ord     = (mode[1:0] > 2'(MAX_ORDER)) ? 2'(MAX_ORDER) : mode[1:0];
  assign m_ord     = (mode[3:2] > 2'(MAX_ORDER)) ? 2'(MAX_ORDER) : mode[3:2];
  assign lead      = (n_ord > m_ord) ? n_ord : m_ord;
  assign use_model = mode[4];
  assign wc_in     = in_data.series_start ? 2'd0 : wcount;
  assign warm_in   = wc_in < lead;

  // ---------------------------------------------------------------- shared MAC
  // Tap 0: b0 * new estimate; taps 1..N: a_i * flow; taps N+1..2N: b_i * estimate.
  // Taps beyond the configured order see a zero coefficient.
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] addend;
  logic signed [63:0] sum;
  logic               sum_ovf;
  logic signed [63:0] sat_sum;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (tap == '0) begin
      mul_a = coef_b0;
      mul_b = est_r;
    end
    for (int i = 0; i < MAX_ORDER; i++) begin
      if (tap == TAP_W'(i + 1) && 2'(i) < n_ord) begin
        mul_a = coef_a[i];
        mul_b = flow_hist[i];
      end
      if (tap == TAP_W'(i + 1 + MAX_ORDER) && 2'(i) < m_ord) begin
        mul_a = coef_b[i];
        mul_b = est_hist[i];
      end
    end
  end

  // Saturating accumulate; the filter pass subtracts, the model pass adds
  assign addend  = (state == airf_pkg::ST_FILT) ? -prod : prod;
  assign sum     = acc + addend;
  assign sum_ovf = (acc[63] == addend[63]) && (sum[63] != acc[63]);
  assign sat_sum = sum_ovf ? (acc[63] ? ACC_MIN : ACC_MAX) : sum;

  // ---------------------------------------------------------------- result shaping
  logic        [31:0] quo_ext;
  logic signed [31:0] div_est;
  logic signed [31:0] kept_sat;

  assign quo_ext = {1'b0, div_res.quo};

  // Quotient clamped to [0, rain]
  always_comb begin
    if (neg || rain_r <= 32'sd0) begin
      div_est = '0;
    end else if (div_res.ovf || $signed(quo_ext) > rain_r) begin
      div_est = rain_r;
    end else begin
      div_est = $signed(quo_ext);
    end
  end

  // Q.40 to Q16.16 with floor and int32 saturation
  always_comb begin
    if (acc[63:55] == {9{acc[63]}}) begin
      kept_sat = acc[55:24];
    end else begin
      kept_sat = acc[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= airf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    case (state)
      airf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = warm_in ? airf_pkg::ST_OUT : airf_pkg::ST_FILT;
      end
      airf_pkg::ST_FILT: begin
        if (tap == TAP_DONE) state_next = airf_pkg::ST_ABS;
      end
      airf_pkg::ST_ABS: begin
        if (coef_b0 == '0) begin
          state_next = use_model ? airf_pkg::ST_MODEL : airf_pkg::ST_OUT;
        end else begin
          state_next = airf_pkg::ST_DSTART;
        end
      end
      airf_pkg::ST_DSTART: begin
        div_start  = 1'b1;
        state_next = airf_pkg::ST_DIV;
      end
      airf_pkg::ST_DIV: begin
        if (div_done) state_next = use_model ? airf_pkg::ST_MODEL : airf_pkg::ST_OUT;
      end
      airf_pkg::ST_MODEL: begin
        if (tap == TAP_DONE) state_next = airf_pkg::ST_KEPT;
      end
      airf_pkg::ST_KEPT: begin
        state_next = airf_pkg::ST_OUT;
      end
      airf_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = airf_pkg::ST_IDLE;
        end
      end
      default: state_next = airf_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- item datapath
  always_ff @(posedge clk) begin
    // Accept: latch the item and seed the filter accumulator with flow in Q.40
    if (state == airf_pkg::ST_IDLE && in_valid) begin
      rain_r  <= in_data.rain;
      est_r   <= in_data.preset_estimate;
      kept_r  <= in_data.flow_obs;
      warm_r  <= warm_in;
      fault_r <= 1'b0;
      acc     <= {{8{in_data.flow_obs[31]}}, in_data.flow_obs, 24'd0};
      tap     <= TAP_W'(1);
      pvld    <= 1'b0;
    end

    // Multiply one tap, accumulate the previous product
    if (state == airf_pkg::ST_FILT || state == airf_pkg::ST_MODEL) begin
      if (tap != TAP_DONE) begin
        prod <= mul_a * mul_b;
        tap  <= tap + TAP_W'(1);
      end
      pvld <= (tap != TAP_DONE);
      if (pvld) acc <= sat_sum;
    end

    // Sign and magnitude for the divider, or the zero-divisor fault
    if (state == airf_pkg::ST_ABS) begin
      neg  <= acc[63] != coef_b0[31];
      mag  <= acc[63] ? 64'(-acc) : 64'(acc);
      dvsr <= coef_b0[31] ? 32'(-coef_b0) : 32'(coef_b0);
      if (coef_b0 == '0) begin
        est_r   <= '0;
        fault_r <= 1'b1;
      end
    end

    if (state == airf_pkg::ST_DIV && div_done) begin
      est_r <= div_est;
    end

    // Model pass starts from an empty accumulator at the b0 tap
    if (state_next == airf_pkg::ST_MODEL && state != airf_pkg::ST_MODEL) begin
      acc  <= '0;
      tap  <= '0;
      pvld <= 1'b0;
    end

    if (state == airf_pkg::ST_KEPT) begin
      kept_r <= kept_sat;
    end
  end

  // ---------------------------------------------------------------- history and output
  always_ff @(posedge clk) begin
    if (rst) begin
      wcount    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        flow_hist[i] <= '0;
        est_hist[i]  <= '0;
      end
    end else begin
      if (state == airf_pkg::ST_IDLE && in_valid) begin
        wcount <= wc_in;
      end
      if (commit) begin
        out_valid <= 1'b1;
        for (int i = MAX_ORDER - 1; i > 0; i--) begin
          flow_hist[i] <= flow_hist[i-1];
          est_hist[i]  <= est_hist[i-1];
        end
        flow_hist[0] <= kept_r;
        est_hist[0]  <= est_r;
        if (wcount != 2'd3) wcount <= wcount + 2'd1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data.estimate  <= est_r;
      out_data.flow_kept <= kept_r;
      out_data.warming   <= warm_r;
      out_data.div_fault <= fault_r;
    end
  end

  // ---------------------------------------------------------------- divider
  airf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (dvsr),
    .done     (div_done),
    .res      (div_res)
  );

endmodule

`default_nettype wire

FILE: design/airf_divider.sv
// Iterative unsigned 64/32 divider, one quotient bit per cycle, with early overflow detect.
`timescale 1ns / 1ps
`default_nettype none

module airf_divider (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [63:0]          dividend,
  input  wire logic [31:0]          divisor,
  output logic                      done,
  output airf_pkg::div_res_t        res
);

  localparam int STEPS = 31;
  localparam int CNT_W = $clog2(STEPS);

  airf_pkg::div_state_t state;
  airf_pkg::div_state_t state_next;

  logic [31:0]      rem;
  logic [30:0]      work;
  logic [CNT_W-1:0] cnt;
  logic             ovf;

  logic [32:0] trial;
  logic        take;
  logic [32:0] diff;
  logic        top_ge;

  // Quotient of 2^31 or more shows up as the high dividend bits reaching the divisor
  assign top_ge = dividend[63:31] >= {1'b0, divisor};

  // One restoring step
  assign trial = {rem, work[30]};
  assign take  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= airf_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      airf_pkg::DIV_IDLE: begin
        if (start && !top_ge) state_next = airf_pkg::DIV_RUN;
      end
      airf_pkg::DIV_RUN: begin
        if (cnt == CNT_W'(STEPS - 1)) state_next = airf_pkg::DIV_IDLE;
      end
      default: state_next = airf_pkg::DIV_IDLE;
    endcase
  end

  // Done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == airf_pkg::DIV_IDLE && start && top_ge) ||
              (state == airf_pkg::DIV_RUN && cnt == CNT_W'(STEPS - 1));
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    case (state)
      airf_pkg::DIV_IDLE: begin
        if (start) begin
          ovf  <= top_ge;
          rem  <= dividend[62:31];
          work <= dividend[30:0];
          cnt  <= '0;
        end
      end
      airf_pkg::DIV_RUN: begin
        rem  <= take ? diff[31:0] : trial[31:0];
        work <= {work[29:0], take};
        cnt  <= cnt + CNT_W'(1);
      end
      default: ;
    endcase
  end

  assign res.ovf = ovf;
  assign res.quo = work;

endmodule

`default_nettype wire

FILE: design/airf_checker.sv
// Port-level checks for the inverse ARMA rainfall filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module airf_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire airf_pkg::airf_out_t out_data
);

  // One item in flight: acceptance closes the input side for the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item was in flight");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A computed estimate is never negative
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.warming |-> !out_data.estimate[31])
    else $error("negative computed estimate");

  // Zero divisor gives a zero estimate, never on a warm-up item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.div_fault |-> out_data.estimate == '0 && !out_data.warming)
    else $error("fault transaction with nonzero estimate or warm-up flag");

endmodule

bind arma_inverse_rainfall_filter airf_checker u_airf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
